FILE: src/versioned_ring_queue_with_reservation_defines.svh
// assertion macros used by the queue top level
`ifndef VERSIONED_RING_QUEUE_WITH_RESERVATION_DEFINES_SVH
`define VERSIONED_RING_QUEUE_WITH_RESERVATION_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define VRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define VRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vrq_pkg.sv
// types and constants of the versioned ring queue
package vrq_pkg;

    localparam int QUEUE_DEPTH   = 4096;
    localparam int SLOT_BITS     = $clog2(QUEUE_DEPTH);
    localparam int INDEX_BITS    = 32;
    localparam int VALUE_BITS    = 64;
    localparam int COUNT_BITS    = 13;
    localparam int FIDX_BITS     = 32;
    localparam int GEN_BITS      = 2;
    localparam int ITEM_CNT_BITS = 12;
    localparam int RIX_BITS      = 32;
    localparam int OP_BITS       = 3;
    localparam int ENTRY_BITS    = VALUE_BITS + INDEX_BITS;
    localparam int IN_DATA_BITS  = 112;
    localparam int OUT_DATA_BITS = 112;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQUEUE   = 3'd0,
        OP_RESERVE   = 3'd1,
        OP_FILL      = 3'd2,
        OP_DEQUEUE   = 3'd3,
        OP_SET_OVF   = 3'd4,
        OP_RESET_OVF = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // one input item
    typedef struct packed {
        op_t                   opcode;
        logic [VALUE_BITS-1:0] item_value;
        logic [COUNT_BITS-1:0] reserve_count;
        logic [FIDX_BITS-1:0]  fill_index;
        logic [GEN_BITS-1:0]   generation;
    } item_t;

    // one result item
    typedef struct packed {
        logic                     success;
        logic [VALUE_BITS-1:0]    out_value;
        logic [RIX_BITS-1:0]      reserved_index;
        logic [ITEM_CNT_BITS-1:0] item_count;
        logic [GEN_BITS-1:0]      overflow_generation;
    } result_t;

endpackage

FILE: src/vrq_ram.sv
// generic simple dual-port ram with registered read
module vrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/vrq_core.sv
// queue control: slot clearing, read-modify-write of slots, index registers
module vrq_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vrq_pkg::item_t   in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output vrq_pkg::result_t res
);

    import vrq_pkg::*;

    state_t                  st_reg, st_next;
    logic [SLOT_BITS-1:0]    clr_reg, clr_next;
    item_t                   item_reg;
    logic [INDEX_BITS-1:0]   enq_reg, enq_next;
    logic [INDEX_BITS-1:0]   deq_reg, deq_next;
    logic [GEN_BITS-1:0]     ovf_reg, ovf_next;

    logic                    ram_we;
    logic [SLOT_BITS-1:0]    ram_waddr;
    logic [ENTRY_BITS-1:0]   ram_wdata;
    logic                    ram_re;
    logic [SLOT_BITS-1:0]    ram_raddr;
    logic [ENTRY_BITS-1:0]   ram_rdata;

    logic [INDEX_BITS-1:0]   rd_tag;
    logic [VALUE_BITS-1:0]   rd_value;
    logic [INDEX_BITS-1:0]   fidx;
    logic [INDEX_BITS-1:0]   resv_span;
    logic [INDEX_BITS-1:0]   deq_gap;
    logic [INDEX_BITS-1:0]   cnt_diff;
    logic                    accept;
    logic                    fire;
    logic                    exec_we;
    logic [SLOT_BITS-1:0]    exec_addr;
    logic [ENTRY_BITS-1:0]   exec_wdata;

    // slot memory: value in the high bits, sequence tag in the low bits
    vrq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_tag   = ram_rdata[INDEX_BITS-1:0];
    assign rd_value = ram_rdata[ENTRY_BITS-1:INDEX_BITS];
    assign accept   = in_valid && in_ready;
    assign fire     = res_valid && res_ready;
    assign fidx     = INDEX_BITS'(item_reg.fill_index);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SLOT_BITS'(QUEUE_DEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    // read address of the slot an incoming item touches
    always_comb
    begin
        unique case (in_item.opcode)
            OP_FILL:    ram_raddr = in_item.fill_index[SLOT_BITS-1:0];
            OP_DEQUEUE: ram_raddr = deq_reg[SLOT_BITS-1:0];
            default:    ram_raddr = enq_reg[SLOT_BITS-1:0];
        endcase
    end

    // operation evaluation on the slot read back
    always_comb
    begin
        res        = '0;
        enq_next   = enq_reg;
        deq_next   = deq_reg;
        ovf_next   = ovf_reg;
        exec_we    = 1'b0;
        exec_addr  = enq_reg[SLOT_BITS-1:0];
        exec_wdata = {rd_value, rd_tag};
        resv_span  = enq_reg + INDEX_BITS'(item_reg.reserve_count) - deq_reg;
        deq_gap    = rd_tag - (deq_reg + INDEX_BITS'(1));
        unique case (item_reg.opcode)
            OP_ENQUEUE:
            begin
                if (rd_tag == enq_reg)
                begin
                    exec_we     = 1'b1;
                    exec_wdata  = {item_reg.item_value, enq_reg + INDEX_BITS'(1)};
                    enq_next    = enq_reg + INDEX_BITS'(1);
                    res.success = 1'b1;
                end
            end
            OP_RESERVE:
            begin
                if (resv_span < INDEX_BITS'(QUEUE_DEPTH - 1))
                begin
                    res.reserved_index = RIX_BITS'(enq_reg);
                    enq_next           = enq_reg + INDEX_BITS'(item_reg.reserve_count);
                    res.success        = 1'b1;
                end
            end
            OP_FILL:
            begin
                exec_we     = 1'b1;
                exec_addr   = fidx[SLOT_BITS-1:0];
                exec_wdata  = {item_reg.item_value, fidx + INDEX_BITS'(1)};
                res.success = (rd_tag == fidx);
            end
            OP_DEQUEUE:
            begin
                exec_addr = deq_reg[SLOT_BITS-1:0];
                if (!deq_gap[INDEX_BITS-1])
                begin
                    exec_we       = 1'b1;
                    exec_wdata    = {rd_value, deq_reg + INDEX_BITS'(QUEUE_DEPTH)};
                    deq_next      = deq_reg + INDEX_BITS'(1);
                    res.out_value = rd_value;
                    res.success   = 1'b1;
                end
            end
            OP_SET_OVF:
            begin
                if (item_reg.generation > ovf_reg)
                begin
                    ovf_next = item_reg.generation;
                end
            end
            OP_RESET_OVF:
            begin
                if ((ovf_reg != '0) && (item_reg.generation >= ovf_reg))
                begin
                    ovf_next = '0;
                end
            end
            default:
            begin
                res.success = 1'b0;
            end
        endcase
        cnt_diff                = enq_next - deq_next;
        res.item_count          = ITEM_CNT_BITS'(cnt_diff[SLOT_BITS-1:0]);
        res.overflow_generation = ovf_next;
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = exec_addr;
        ram_wdata = exec_wdata;
        clr_next  = clr_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {{VALUE_BITS{1'b0}}, INDEX_BITS'(clr_reg)};
                clr_next  = clr_reg + SLOT_BITS'(1);
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_re   = accept;
            end
            ST_EXEC:
            begin
                res_valid = 1'b1;
                ram_we    = fire && exec_we;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
            enq_reg <= '0;
            deq_reg <= '0;
            ovf_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (fire)
            begin
                enq_reg <= enq_next;
                deq_reg <= deq_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: src/versioned_ring_queue_with_reservation.sv
// an accepted item reads its slot; result and slot write-back take effect as the
// result enters the output register. Items are taken one at a time, set by the slot
// read then write-back in the single slot memory; a result held in the output
// register does not block the next item. reset: indices and overflow generation
// clear at once, then a pass sets each slot tag to its index with s_tready held low
module versioned_ring_queue_with_reservation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // item_value[63:0], reserve_count[76:64], fill_index[108:77], generation[110:109]
    input  logic [vrq_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // opcode[2:0]
    input  logic [vrq_pkg::OP_BITS-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // success[0], out_value[64:1], reserved_index[96:65], item_count[108:97],
    // overflow_generation[110:109]
    output logic [vrq_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

    import vrq_pkg::*;

    `include "versioned_ring_queue_with_reservation_defines.svh"

    item_t   in_item;
    result_t res;
    result_t res_reg;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg;

    // unpack the input item
    always_comb
    begin
        in_item.opcode        = op_t'(s_tuser);
        in_item.item_value    = s_tdata[VALUE_BITS-1:0];
        in_item.reserve_count = s_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS];
        in_item.fill_index    = s_tdata[VALUE_BITS+COUNT_BITS+FIDX_BITS-1:
                                        VALUE_BITS+COUNT_BITS];
        in_item.generation    = s_tdata[VALUE_BITS+COUNT_BITS+FIDX_BITS+GEN_BITS-1:
                                        VALUE_BITS+COUNT_BITS+FIDX_BITS];
    end

    vrq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        1'b0,
        res_reg.overflow_generation,
        res_reg.item_count,
        res_reg.reserved_index,
        res_reg.out_value,
        res_reg.success
    };

    // checks
    `VRQ_ASSERT_NOW(a_no_accept_while_busy, s_tvalid && s_tready, !res_valid, "accept while busy")
    `VRQ_ASSERT_NEXT(a_result_done, res_valid && res_ready, !res_valid, "result repeated")
    `VRQ_ASSERT_NEXT(a_result_out, res_valid && res_ready, m_tvalid, "result not on output")
    `VRQ_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, res_valid && !s_tready, "not busy")

endmodule

FILE: tb/vrq_result_checker.sv
// result checker for the versioned ring queue: predicts each item and compares results
module vrq_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // item_value, reserve_count, fill_index, generation
    input  logic [vrq_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // opcode
    input  logic [vrq_pkg::OP_BITS-1:0]       s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // success, out_value, reserved_index, item_count, overflow_generation
    input  logic [vrq_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input  logic                              end_of_test,
    output int unsigned                       fail_count
);

    import vrq_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // predicted queue state
    logic [INDEX_BITS-1:0] enq_idx;
    logic [INDEX_BITS-1:0] deq_idx;
    logic [INDEX_BITS-1:0] tag_mem [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] value_mem [QUEUE_DEPTH];
    logic [GEN_BITS-1:0]   ovf_gen;

    result_t     pending_results [$];
    result_t     predicted;
    result_t     observed;
    result_t     wanted;
    bit          leftover_counted;
    int unsigned results_checked;

    // apply one item to the predicted state and form its result
    task automatic step_queue(
        input  logic [OP_BITS-1:0]    op,
        input  logic [VALUE_BITS-1:0] value,
        input  logic [COUNT_BITS-1:0] cnt,
        input  logic [FIDX_BITS-1:0]  fidx,
        input  logic [GEN_BITS-1:0]   gen,
        output result_t               res
    );
        logic [SLOT_BITS-1:0]  slot;
        logic [INDEX_BITS-1:0] lead;
        res = '0;
        case (op)
            OP_ENQUEUE:
            begin
                slot = enq_idx[SLOT_BITS-1:0];
                if (tag_mem[slot] == enq_idx)
                begin
                    value_mem[slot] = value;
                    tag_mem[slot]   = enq_idx + 1;
                    enq_idx         = enq_idx + 1;
                    res.success     = 1'b1;
                end
            end
            OP_RESERVE:
            begin
                lead = enq_idx + INDEX_BITS'(cnt) - deq_idx;
                if (lead < QUEUE_DEPTH - 1)
                begin
                    res.reserved_index = enq_idx[RIX_BITS-1:0];
                    enq_idx            = enq_idx + INDEX_BITS'(cnt);
                    res.success        = 1'b1;
                end
            end
            OP_FILL:
            begin
                slot            = fidx[SLOT_BITS-1:0];
                res.success     = (tag_mem[slot] == fidx);
                value_mem[slot] = value;
                tag_mem[slot]   = fidx + 1;
            end
            OP_DEQUEUE:
            begin
                slot = deq_idx[SLOT_BITS-1:0];
                lead = tag_mem[slot] - (deq_idx + 1);
                // a tag ahead of the index still counts as ready
                if (!lead[INDEX_BITS-1])
                begin
                    res.out_value = value_mem[slot];
                    tag_mem[slot] = deq_idx + QUEUE_DEPTH;
                    deq_idx       = deq_idx + 1;
                    res.success   = 1'b1;
                end
            end
            OP_SET_OVF:
            begin
                if (gen > ovf_gen)
                    ovf_gen = gen;
            end
            OP_RESET_OVF:
            begin
                if (ovf_gen != 0 && gen >= ovf_gen)
                    ovf_gen = '0;
            end
            default:
            begin
            end
        endcase
        lead = enq_idx - deq_idx;
        res.item_count          = lead[ITEM_CNT_BITS-1:0];
        res.overflow_generation = ovf_gen;
    endtask

    // watch both channels on the falling edge, ahead of the accepting edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            enq_idx          = '0;
            deq_idx          = '0;
            ovf_gen          = '0;
            fail_count       = 0;
            results_checked  = 0;
            leftover_counted = 1'b0;
            pending_results.delete();
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                tag_mem[i]   = INDEX_BITS'(i);
                value_mem[i] = '0;
            end
        end
        else
        begin
            // result side first so an early result cannot match its own item
            if (m_tvalid && m_tready)
            begin
                observed.success             = m_tdata[0];
                observed.out_value           = m_tdata[64:1];
                observed.reserved_index      = m_tdata[96:65];
                observed.item_count          = m_tdata[108:97];
                observed.overflow_generation = m_tdata[110:109];
                if (pending_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("unexpected result %0d: ok=%0d val=%h rix=%h cnt=%0d ovf=%0d",
                                 results_checked, observed.success, observed.out_value,
                                 observed.reserved_index, observed.item_count,
                                 observed.overflow_generation);
                    fail_count++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (observed.success !== wanted.success ||
                        observed.out_value !== wanted.out_value ||
                        observed.reserved_index !== wanted.reserved_index ||
                        observed.item_count !== wanted.item_count ||
                        observed.overflow_generation !== wanted.overflow_generation)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display("result %0d mismatch", results_checked);
                            $display("  expected ok=%0d val=%h rix=%h cnt=%0d ovf=%0d",
                                     wanted.success, wanted.out_value, wanted.reserved_index,
                                     wanted.item_count, wanted.overflow_generation);
                            $display("  actual   ok=%0d val=%h rix=%h cnt=%0d ovf=%0d",
                                     observed.success, observed.out_value,
                                     observed.reserved_index, observed.item_count,
                                     observed.overflow_generation);
                        end
                        fail_count++;
                    end
                end
                results_checked++;
            end

            // input side: predict and queue the expected result
            if (s_tvalid && s_tready)
            begin
                step_queue(s_tuser, s_tdata[63:0], s_tdata[76:64], s_tdata[108:77],
                           s_tdata[110:109], predicted);
                pending_results.push_back(predicted);
            end

            // anything still waiting at the end never arrived
            if (end_of_test && !leftover_counted)
            begin
                if (pending_results.size() != 0)
                    $display("%0d expected results never arrived", pending_results.size());
                fail_count       = fail_count + pending_results.size();
                leftover_counted = 1'b1;
            end
        end
    end

endmodule

FILE: tb/tb_versioned_ring_queue_with_reservation.sv
// stimulus and verdict for the versioned ring queue with reservation
module tb_versioned_ring_queue_with_reservation;

    import vrq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic [OP_BITS-1:0]       s_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     end_of_test;
    int unsigned              fail_count;

    int unsigned              send_idle_pct = 31;
    int unsigned              recv_idle_pct = 55;
    int unsigned              items_sent    = 0;
    int unsigned              results_seen  = 0;
    int unsigned              successes     = 0;
    int unsigned              cycle_count   = 0;
    int unsigned              op_tally [8];
    logic [OUT_DATA_BITS-1:0] last_result   = '0;
    logic [INDEX_BITS-1:0]    open_slots [$];

    versioned_ring_queue_with_reservation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vrq_result_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .end_of_test (end_of_test),
        .fail_count  (fail_count)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // track returned results for reservation feedback and draining
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            results_seen++;
            last_result = m_tdata;
            if (m_tdata[0])
                successes++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** versioned_ring_queue_with_reservation: FAILED **");
            $finish;
        end
    end

    function automatic logic [VALUE_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [COUNT_BITS-1:0] any_count();
        return COUNT_BITS'($urandom_range(QUEUE_DEPTH));
    endfunction

    function automatic logic [GEN_BITS-1:0] any_gen();
        return GEN_BITS'($urandom_range(3));
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(
        input logic [OP_BITS-1:0]    op,
        input logic [VALUE_BITS-1:0] value,
        input logic [COUNT_BITS-1:0] cnt,
        input logic [FIDX_BITS-1:0]  fidx,
        input logic [GEN_BITS-1:0]   gen
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, gen, fidx, cnt, value};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        op_tally[op]++;
    endtask

    // hold off the sender until every result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(negedge clk);
        @(posedge clk);
    endtask

    // reserve a block and read back where it starts
    task automatic reserve_block(
        input  logic [COUNT_BITS-1:0] cnt,
        output bit                    ok,
        output logic [INDEX_BITS-1:0] first
    );
        send_item(OP_RESERVE, rand64(), cnt, $urandom, any_gen());
        wait_for_results();
        ok    = last_result[0];
        first = last_result[96:65];
    endtask

    task automatic fill_slot(input logic [INDEX_BITS-1:0] idx);
        send_item(OP_FILL, rand64(), any_count(), idx, any_gen());
    endtask

    // mostly well-formed traffic: bursts, reserve-then-fill, some noise
    task automatic run_random(input int unsigned quota);
        int unsigned           stop_at;
        int unsigned           pick;
        int unsigned           k;
        int unsigned           c;
        bit                    ok;
        logic [INDEX_BITS-1:0] first;
        logic [INDEX_BITS-1:0] tmp;
        logic [INDEX_BITS-1:0] block [$];
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 26)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(OP_ENQUEUE, rand64(), any_count(), $urandom, any_gen());
            end
            else if (pick < 60)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(OP_DEQUEUE, rand64(), any_count(), $urandom, any_gen());
            end
            else if (pick < 78)
            begin
                c = $urandom_range(1, 8);
                reserve_block(COUNT_BITS'(c), ok, first);
                if (ok)
                begin
                    block.delete();
                    for (k = 0; k < c; k++)
                        block.push_back(first + k);
                    for (k = 0; k < c; k++)
                    begin
                        pick       = $urandom_range(c - 1);
                        tmp        = block[k];
                        block[k]   = block[pick];
                        block[pick] = tmp;
                    end
                    // most slots filled at once, a few left for later
                    foreach (block[i])
                    begin
                        if ($urandom_range(99) < 85)
                            fill_slot(block[i]);
                        else
                            open_slots.push_back(block[i]);
                    end
                end
            end
            else if (pick < 84)
            begin
                if (open_slots.size() != 0)
                begin
                    k = $urandom_range(open_slots.size() - 1);
                    fill_slot(open_slots[k]);
                    open_slots.delete(k);
                end
            end
            else if (pick < 90)
            begin
                send_item($urandom_range(1) ? OP_SET_OVF : OP_RESET_OVF, rand64(),
                          any_count(), $urandom, any_gen());
            end
            else if (pick < 93)
            begin
                send_item(OP_RESERVE, rand64(), '0, $urandom, any_gen());
            end
            else if (pick < 96)
            begin
                // reserve too large to fit, from the smallest refused size upward
                wait_for_results();
                c = 32'(last_result[108:97]);
                send_item(OP_RESERVE, rand64(),
                          COUNT_BITS'($urandom_range(QUEUE_DEPTH, QUEUE_DEPTH - 1 - c)),
                          $urandom, any_gen());
            end
            else
            begin
                fill_slot($urandom);
            end
        end
        wait_for_results();
    endtask

    // stimulus
    initial
    begin
        bit                    ok;
        logic [INDEX_BITS-1:0] first;
        logic [INDEX_BITS-1:0] base;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_ENQUEUE;
        end_of_test <= 1'b0;
        foreach (op_tally[i])
            op_tally[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty dequeue, extreme values through the queue
        send_item(OP_DEQUEUE, rand64(), '0, '0, '0);
        send_item(OP_ENQUEUE, '0, '0, '0, '0);
        send_item(OP_ENQUEUE, '1, '0, '0, '0);
        send_item(OP_DEQUEUE, '0, '0, '0, '0);
        send_item(OP_DEQUEUE, '0, '0, '0, '0);

        // oversized reservations refused, zero-size reservation
        send_item(OP_RESERVE, rand64(), COUNT_BITS'(QUEUE_DEPTH), '0, '0);
        send_item(OP_RESERVE, rand64(), COUNT_BITS'(QUEUE_DEPTH - 1), '0, '0);
        send_item(OP_RESERVE, rand64(), '0, '0, '0);

        // reserve two, fill out of order, drain them
        reserve_block(COUNT_BITS'(2), ok, first);
        fill_slot(first + 1);
        fill_slot(first);
        send_item(OP_DEQUEUE, '0, '0, '0, '0);
        send_item(OP_DEQUEUE, '0, '0, '0, '0);

        // fill index extremes
        fill_slot('1);
        fill_slot('0);

        // enqueue blocked by a tag behind, then by a tag ahead
        base = first + 2;
        fill_slot(base - QUEUE_DEPTH);
        send_item(OP_ENQUEUE, rand64(), '0, '0, '0);
        fill_slot(base);
        send_item(OP_ENQUEUE, rand64(), '0, '0, '0);
        send_item(OP_RESERVE, rand64(), COUNT_BITS'(1), '0, '0);
        send_item(OP_DEQUEUE, '0, '0, '0, '0);

        // overflow generation raise, ignored lower values, clear
        send_item(OP_SET_OVF, '0, '0, '0, 2'd2);
        send_item(OP_SET_OVF, '0, '0, '0, 2'd1);
        send_item(OP_RESET_OVF, '0, '0, '0, 2'd1);
        send_item(OP_RESET_OVF, '0, '0, '0, 2'd3);
        send_item(OP_SET_OVF, '0, '0, '0, 2'd3);

        // unused opcodes
        send_item(OP_SPARE_6, rand64(), any_count(), $urandom, any_gen());
        send_item(OP_SPARE_7, rand64(), any_count(), $urandom, any_gen());
        wait_for_results();

        // random traffic under three backpressure mixes
        run_random(600);
        send_idle_pct = 55;
        recv_idle_pct = 31;
        run_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(500);

        // let the pipeline settle, then close the books
        repeat (4) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d items: %0d enqueue, %0d reserve, %0d fill,",
                 items_sent, op_tally[OP_ENQUEUE], op_tally[OP_RESERVE], op_tally[OP_FILL]);
        $display("%0d dequeue, %0d ovf ops; %0d results under three stall mixes, %0d ok",
                 op_tally[OP_DEQUEUE], op_tally[OP_SET_OVF] + op_tally[OP_RESET_OVF],
                 results_seen, successes);
        if (fail_count == 0)
            $display("** versioned_ring_queue_with_reservation: PASSED **");
        else
            $display("** versioned_ring_queue_with_reservation: FAILED **");
        $finish;
    end

endmodule
